FILE: hw/rtl/lpfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfe_pkg
// Shared types and constants of the LED pixel frame encoder.
// ----------------------------------------------------------------------------
package lpfe_pkg;

  localparam int MAX_PIXELS = 1024;
  localparam int ADDR_W     = 16;
  localparam int CNT_W      = 5;
  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    MODE_RTZ_RGB  = 3'd0,
    MODE_RTZ_GRBW = 3'd1,
    MODE_BYTE_RGB = 3'd2,
    MODE_BRIGHT   = 3'd3,
    MODE_FLAG     = 3'd4
  } mode_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PROTOCOL_MODE     = 2'd0,
    REG_LOW_CODE          = 2'd1,
    REG_HIGH_CODE         = 2'd2,
    REG_GLOBAL_BRIGHTNESS = 2'd3
  } reg_idx_t;

  localparam logic [CNT_W-1:0] LAST_RTZ_RGB  = 5'd23;
  localparam logic [CNT_W-1:0] LAST_RTZ_GRBW = 5'd31;
  localparam logic [CNT_W-1:0] LAST_BYTE3    = 5'd2;
  localparam logic [CNT_W-1:0] LAST_BYTE4    = 5'd3;

  localparam logic [ADDR_W-1:0] RTZ_OFFSET    = 16'd1;
  localparam logic [ADDR_W-1:0] HEADER_OFFSET = 16'd4;
  localparam logic [1:0]        FLAG_TOP      = 2'b11;

  typedef struct packed {
    logic [9:0] pixel_number;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [7:0] white_level;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] byte_address;
    logic [7:0]  byte_value;
    logic        last_write;
  } pix_out_t;

  // one pixel job handed from the front end to the write sequencer
  typedef struct packed {
    logic [ADDR_W-1:0] base_addr;
    logic [31:0]       payload;
    logic [CNT_W-1:0]  last_idx;
    logic              rtz;
    logic [7:0]        low_code;
    logic [7:0]        high_code;
  } job_t;

endpackage

FILE: hw/rtl/lpfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfe_front
// Holds the configuration registers, accepts pixels and turns each in-range
// pixel of a defined mode into a job: address, byte or bit payload, write count.
// ----------------------------------------------------------------------------
module lpfe_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [lpfe_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [lpfe_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lpfe_pkg::pix_in_t                   in_word,
  input  logic                                q_full,
  output logic                                q_push,
  output lpfe_pkg::job_t                      q_job
);
  import lpfe_pkg::*;

  mode_t      mode_r;
  logic [7:0] low_code_r;
  logic [7:0] high_code_r;
  logic [7:0] bright_r;

  logic [ADDR_W-1:0] pix16;
  logic              in_range;
  logic              mode_ok;
  logic [7:0]        flag_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RTZ_RGB;
      low_code_r  <= '0;
      high_code_r <= '0;
      bright_r    <= '0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_PROTOCOL_MODE:     mode_r      <= mode_t'(cfg_wdata[2:0]);
        REG_LOW_CODE:          low_code_r  <= cfg_wdata[7:0];
        REG_HIGH_CODE:         high_code_r <= cfg_wdata[7:0];
        REG_GLOBAL_BRIGHTNESS: bright_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign pix16     = ADDR_W'(in_word.pixel_number);
  assign in_range  = 32'(in_word.pixel_number) < 32'(MAX_PIXELS);
  assign flag_byte = {FLAG_TOP, ~in_word.blue_level[7:6], ~in_word.green_level[7:6],
                      ~in_word.red_level[7:6]};

  always_comb begin
    q_job           = '0;
    q_job.low_code  = low_code_r;
    q_job.high_code = high_code_r;
    mode_ok         = 1'b1;
    case (mode_r)
      MODE_RTZ_RGB: begin
        q_job.base_addr = (pix16 << 4) + (pix16 << 3) + RTZ_OFFSET;
        q_job.payload   = {in_word.red_level, in_word.green_level, in_word.blue_level, 8'h00};
        q_job.last_idx  = LAST_RTZ_RGB;
        q_job.rtz       = 1'b1;
      end
      MODE_RTZ_GRBW: begin
        q_job.base_addr = (pix16 << 5) + RTZ_OFFSET;
        q_job.payload   = {in_word.green_level, in_word.red_level, in_word.blue_level,
                           in_word.white_level};
        q_job.last_idx  = LAST_RTZ_GRBW;
        q_job.rtz       = 1'b1;
      end
      MODE_BYTE_RGB: begin
        q_job.base_addr = (pix16 << 1) + pix16;
        q_job.payload   = {in_word.red_level, in_word.green_level, in_word.blue_level, 8'h00};
        q_job.last_idx  = LAST_BYTE3;
      end
      MODE_BRIGHT: begin
        q_job.base_addr = (pix16 << 2) + HEADER_OFFSET;
        q_job.payload   = {bright_r, in_word.red_level, in_word.green_level,
                           in_word.blue_level};
        q_job.last_idx  = LAST_BYTE4;
      end
      MODE_FLAG: begin
        q_job.base_addr = (pix16 << 2) + HEADER_OFFSET;
        q_job.payload   = {flag_byte, in_word.blue_level, in_word.green_level,
                           in_word.red_level};
        q_job.last_idx  = LAST_BYTE4;
      end
      default: begin
        mode_ok = 1'b0;
      end
    endcase
  end

  // pixels out of range or under an undefined mode are taken and dropped
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && in_range && mode_ok;

endmodule

FILE: hw/rtl/lpfe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfe_queue
// Short job queue between the front end and the write sequencer.
// ----------------------------------------------------------------------------
module lpfe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lpfe_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output lpfe_pkg::job_t  head_job
);
  import lpfe_pkg::*;

  job_t              entries_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign full      = count_r == QCNT_W'(QDEPTH);
  assign not_empty = count_r != '0;
  assign head_job  = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full job queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("pop from empty job queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= QDEPTH)
    else $error("job queue count beyond depth");

endmodule

FILE: hw/rtl/lpfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfe_back
// Write sequencer: steps through one job, one frame-buffer byte write per
// cycle while the output does not stall, into a registered output stage.
// ----------------------------------------------------------------------------
module lpfe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  lpfe_pkg::job_t     q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lpfe_pkg::pix_out_t out_word
);
  import lpfe_pkg::*;

  logic              busy_r;
  logic [ADDR_W-1:0] addr_r;
  logic [31:0]       payload_r;
  logic [CNT_W-1:0]  remain_r;
  logic              rtz_r;
  logic [7:0]        low_r;
  logic [7:0]        high_r;

  logic              out_valid_r;
  pix_out_t          out_word_r;

  logic              can_load;
  logic              emit;
  logic              emit_last;
  logic [7:0]        emit_value;

  assign can_load   = !out_valid_r || !out_stall;
  assign emit       = busy_r && can_load;
  assign emit_last  = remain_r == '0;
  assign emit_value = rtz_r ? (payload_r[31] ? high_r : low_r) : payload_r[31:24];
  assign q_pop      = q_not_empty && (!busy_r || (emit && emit_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
    end else if (emit && emit_last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      addr_r    <= q_head.base_addr;
      payload_r <= q_head.payload;
      remain_r  <= q_head.last_idx;
      rtz_r     <= q_head.rtz;
      low_r     <= q_head.low_code;
      high_r    <= q_head.high_code;
    end else if (emit) begin
      addr_r    <= addr_r + 1'b1;
      payload_r <= rtz_r ? {payload_r[30:0], 1'b0} : {payload_r[23:0], 8'h00};
      remain_r  <= remain_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_load) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r.byte_address <= addr_r;
      out_word_r.byte_value   <= emit_value;
      out_word_r.last_write   <= emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_stay_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !emit_last) |=> busy_r)
    else $error("sequencer left a job before its last write");
  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !rtz_r) |-> (remain_r <= LAST_BYTE4))
    else $error("byte job count out of range");
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (out_valid_r && out_word_r.last_write))
    else $error("final write not flagged");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !emit) |-> !q_pop)
    else $error("job loaded over an unfinished one");

endmodule

FILE: hw/rtl/led_pixel_frame_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pixel_frame_encoder
// Turns one pixel into the frame-buffer byte writes of the selected LED
// protocol.
// ----------------------------------------------------------------------------
// Each accepted pixel produces one byte write per cycle on the result side
// while the output does not stall: 24 writes in rtz rgb mode, 32 in rtz
// grbw mode, 3 in three-byte mode and 4 in the two header modes. The front
// end takes a pixel every cycle while the two-entry job queue has room, so
// pixels queue up while earlier writes drain, and the sequencer moves from
// one pixel's last write to the next pixel's first with no gap when the next
// pixel is already queued. Pixels at or beyond the strip length, or sent
// under an undefined mode, are taken while the queue has room and give no
// writes. Configuration may be written only while no pixel is in flight.
module led_pixel_frame_encoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [lpfe_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [lpfe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lpfe_pkg::pix_in_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lpfe_pkg::pix_out_t              out_word
);
  import lpfe_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_not_empty;
  job_t push_job;
  job_t head_job;

  lpfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  lpfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  lpfe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (head_job),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule

FILE: test/led_pixel_frame_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pixel_frame_encoder_tb
// Self-checking bench for the LED pixel frame encoder.
// ----------------------------------------------------------------------------
// A directed table walks the field extremes, every protocol mode and the
// undefined modes that drop the pixel. Random phases then change the register
// setting and send random pixels. The byte writes each pixel should cause are
// worked out here and compared in order, field by field, with every word the
// block delivers. Both sides idle and stall at random, one phase runs with no
// idling, and once the output side holds off long enough to back up the
// input.
// ----------------------------------------------------------------------------
module led_pixel_frame_encoder_tb;
  import lpfe_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PIXELS  = 300;

  typedef struct {
    logic [2:0] mode;
    logic [7:0] low;
    logic [7:0] high;
    logic [7:0] bright;
    pix_in_t    px;
    bit         typed;
    pix_out_t   first;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_wr_en;
  reg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic     in_valid;
  logic     in_stall;
  pix_in_t  in_word;
  logic     out_valid;
  logic     out_stall;
  pix_out_t out_word;

  logic [2:0] mode_q;
  logic [7:0] low_q;
  logic [7:0] high_q;
  logic [7:0] bright_q;

  pix_out_t write_q[$];
  dir_row_t dir_tab[$];
  int errors   = 0;
  int idle_cnt = 0;
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  led_pixel_frame_encoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // byte writes of one pixel under the current setting
  function automatic void encode_pixel(input pix_in_t px, input bit typed,
                                       input pix_out_t first, output int n);
    logic [31:0] bits;
    logic [7:0]  lane [4];
    logic [15:0] base;
    logic [7:0]  r, g, b, flag;
    bit          rtz;
    pix_out_t    w;
    r    = px.red_level;
    g    = px.green_level;
    b    = px.blue_level;
    flag = 8'hC0 | ((~b & 8'hC0) >> 2) | ((~g & 8'hC0) >> 4) | ((~r & 8'hC0) >> 6);
    n    = 0;
    rtz  = 1'b0;
    bits = '0;
    base = '0;
    lane = '{8'h00, 8'h00, 8'h00, 8'h00};
    if (px.pixel_number >= MAX_PIXELS) return;
    case (mode_q)
      MODE_RTZ_RGB: begin
        rtz  = 1'b1;
        n    = 24;
        bits = {r, g, b, 8'h00};
        base = 16'(px.pixel_number) * 16'd24 + 16'd1;
      end
      MODE_RTZ_GRBW: begin
        rtz  = 1'b1;
        n    = 32;
        bits = {g, r, b, px.white_level};
        base = 16'(px.pixel_number) * 16'd32 + 16'd1;
      end
      MODE_BYTE_RGB: begin
        n    = 3;
        lane = '{r, g, b, 8'h00};
        base = 16'(px.pixel_number) * 16'd3;
      end
      MODE_BRIGHT: begin
        n    = 4;
        lane = '{bright_q, r, g, b};
        base = 16'd4 + 16'(px.pixel_number) * 16'd4;
      end
      MODE_FLAG: begin
        n    = 4;
        lane = '{flag, b, g, r};
        base = 16'd4 + 16'(px.pixel_number) * 16'd4;
      end
      default: n = 0;
    endcase
    for (int k = 0; k < n; k++) begin
      w.byte_address = base + 16'(k);
      w.byte_value   = rtz ? (bits[31-k] ? high_q : low_q) : lane[k];
      w.last_write   = (k == n - 1);
      if (typed && k == 0) w = first;
      write_q.push_back(w);
    end
  endfunction

  task automatic add_row(input logic [2:0] m, input logic [7:0] lo, hi, br,
                         input logic [9:0] p, input logic [7:0] r, g, b, wh,
                         input bit typed = 1'b0, input logic [15:0] a = '0,
                         input logic [7:0] v = '0);
    dir_row_t row;
    row.mode                 = m;
    row.low                  = lo;
    row.high                 = hi;
    row.bright               = br;
    row.px.pixel_number      = p;
    row.px.red_level         = r;
    row.px.green_level       = g;
    row.px.blue_level        = b;
    row.px.white_level       = wh;
    row.typed                = typed;
    row.first.byte_address   = a;
    row.first.byte_value     = v;
    row.first.last_write     = 1'b0;
    dir_tab.push_back(row);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_pixel(input pix_in_t px, input bit typed, input pix_out_t first,
                            output int n);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_word  <= px;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_pixel(px, typed, first, n);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (write_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [2:0] m, input logic [7:0] lo, hi, br);
    drain();
    write_reg(REG_PROTOCOL_MODE, {5'($urandom), m});
    write_reg(REG_LOW_CODE, lo);
    write_reg(REG_HIGH_CODE, hi);
    write_reg(REG_GLOBAL_BRIGHTNESS, br);
    cfg_wr_en <= 1'b0;
    mode_q   = m;
    low_q    = lo;
    high_q   = hi;
    bright_q = br;
  endtask

  // output side: random stalls, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 34);
      end
    end
  end

  always @(posedge clk) begin : check_words
    pix_out_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
      else idle_cnt = idle_cnt + 1;
      if (out_valid && !out_stall) begin
        if (write_q.size() == 0) begin
          $error("unexpected word: address %0d value %0h", out_word.byte_address,
                 out_word.byte_value);
          errors++;
        end else begin
          want = write_q.pop_front();
          if (out_word.byte_address !== want.byte_address) begin
            $error("byte_address: expected %0d, got %0d", want.byte_address,
                   out_word.byte_address);
            errors++;
          end
          if (out_word.byte_value !== want.byte_value) begin
            $error("byte_value: expected %0h, got %0h", want.byte_value,
                   out_word.byte_value);
            errors++;
          end
          if (out_word.last_write !== want.last_write) begin
            $error("last_write: expected %0b, got %0b", want.last_write,
                   out_word.last_write);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    while (idle_cnt < WATCHDOG_LIMIT) @(posedge clk);
    $display("led_pixel_frame_encoder: mismatch");
    $finish;
  end

  initial begin
    dir_row_t   row;
    pix_in_t    px;
    logic [2:0] m;
    logic [7:0] lo, hi, br;
    int         n, good, phase, n_items;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_PROTOCOL_MODE;
    cfg_wdata = '0;
    mode_q    = '0;
    low_q     = '0;
    high_q    = '0;
    bright_q  = '0;

    // setting after reset
    add_row(MODE_RTZ_RGB, 8'h00, 8'h00, 8'h00, 10'd0, 8'h00, 8'h00, 8'h00, 8'h00,
            1'b1, 16'd1, 8'h00);
    add_row(MODE_RTZ_RGB, 8'h00, 8'hFF, 8'h00, 10'd1023, 8'hFF, 8'h00, 8'hAA, 8'h55,
            1'b1, 16'd24553, 8'hFF);
    add_row(MODE_RTZ_RGB, 8'h00, 8'hFF, 8'h00, 10'd0, 8'h00, 8'hFF, 8'h55, 8'hAA);
    add_row(MODE_RTZ_GRBW, 8'hFF, 8'h00, 8'h00, 10'd1023, 8'hFF, 8'h00, 8'hFF, 8'h00,
            1'b1, 16'd32737, 8'hFF);
    add_row(MODE_RTZ_GRBW, 8'hFF, 8'h00, 8'h00, 10'd0, 8'hAA, 8'h55, 8'hFF, 8'hFF);
    add_row(MODE_RTZ_GRBW, 8'hFF, 8'h00, 8'h00, 10'd512, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(MODE_BYTE_RGB, 8'h80, 8'hC0, 8'h00, 10'd1023, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            1'b1, 16'd3069, 8'hFF);
    add_row(MODE_BYTE_RGB, 8'h80, 8'hC0, 8'h00, 10'd0, 8'h00, 8'h00, 8'h00, 8'h00,
            1'b1, 16'd0, 8'h00);
    add_row(MODE_BYTE_RGB, 8'h80, 8'hC0, 8'h00, 10'd341, 8'h12, 8'h34, 8'h56, 8'h78);
    add_row(MODE_BRIGHT, 8'h80, 8'hC0, 8'hFF, 10'd0, 8'h00, 8'h00, 8'h00, 8'h00,
            1'b1, 16'd4, 8'hFF);
    add_row(MODE_BRIGHT, 8'h80, 8'hC0, 8'hFF, 10'd1023, 8'h5A, 8'hA5, 8'h3C, 8'h00,
            1'b1, 16'd4096, 8'hFF);
    add_row(MODE_BRIGHT, 8'h80, 8'hC0, 8'h00, 10'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            1'b1, 16'd32, 8'h00);
    add_row(MODE_FLAG, 8'h80, 8'hC0, 8'h00, 10'd0, 8'h00, 8'h00, 8'h00, 8'h00,
            1'b1, 16'd4, 8'hFF);
    add_row(MODE_FLAG, 8'h80, 8'hC0, 8'h00, 10'd1023, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            1'b1, 16'd4096, 8'hC0);
    add_row(MODE_FLAG, 8'h80, 8'hC0, 8'h00, 10'd100, 8'h40, 8'h80, 8'hC0, 8'h11);
    add_row(MODE_FLAG, 8'h80, 8'hC0, 8'h00, 10'd200, 8'h80, 8'hC0, 8'h00, 8'h22);
    // undefined modes drop the pixel
    add_row(3'd5, 8'h80, 8'hC0, 8'h00, 10'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_row(3'd6, 8'h80, 8'hC0, 8'h00, 10'd2, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(3'd7, 8'h80, 8'hC0, 8'h00, 10'd1023, 8'hAA, 8'h55, 8'hAA, 8'h55);
    add_row(MODE_RTZ_RGB, 8'hAA, 8'h55, 8'h00, 10'd5, 8'hF0, 8'h0F, 8'h3C, 8'h00);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.mode != mode_q || row.low != low_q || row.high != high_q ||
          row.bright != bright_q)
        apply_setting(row.mode, row.low, row.high, row.bright);
      send_pixel(row.px, row.typed, row.first, n);
    end

    good  = 0;
    phase = 0;
    while (good < RANDOM_PIXELS) begin
      if (phase != 5 && $urandom_range(99) < 12) m = 3'($urandom_range(5, 7));
      else m = 3'($urandom_range(0, 4));
      case (phase)
        0: begin lo = 8'h00; hi = 8'hFF; br = 8'hFF; end
        1: begin lo = 8'hFF; hi = 8'h00; br = 8'h00; end
        default: begin
          lo = ($urandom_range(99) < 20) ? {8{1'($urandom)}} : 8'($urandom);
          hi = ($urandom_range(99) < 20) ? {8{1'($urandom)}} : 8'($urandom);
          br = ($urandom_range(99) < 20) ? {8{1'($urandom)}} : 8'($urandom);
        end
      endcase
      apply_setting(m, lo, hi, br);
      calm    = (phase == 3);
      n_items = (m > MODE_FLAG) ? 4 : 30;
      for (int k = 0; k < n_items; k++) begin
        if (phase == 5 && k == 8) hold_req = 1'b1;
        case ($urandom_range(9))
          0:       px.pixel_number = 10'd0;
          1:       px.pixel_number = 10'd1023;
          default: px.pixel_number = 10'($urandom);
        endcase
        if ($urandom_range(9) == 0) begin
          px.red_level   = {8{1'($urandom)}};
          px.green_level = {8{1'($urandom)}};
          px.blue_level  = {8{1'($urandom)}};
          px.white_level = {8{1'($urandom)}};
        end else begin
          {px.red_level, px.green_level, px.blue_level, px.white_level} = $urandom;
        end
        send_pixel(px, 1'b0, '0, n);
        if (n > 0) good++;
      end
      phase++;
    end
    calm = 1'b0;

    drain();
    if (errors == 0 && write_q.size() == 0) begin
      $display("led_pixel_frame_encoder: match");
    end else begin
      $display("led_pixel_frame_encoder: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lpfe_pkg.sv
hw/rtl/lpfe_front.sv
hw/rtl/lpfe_queue.sv
hw/rtl/lpfe_back.sv
hw/rtl/led_pixel_frame_encoder.sv
test/led_pixel_frame_encoder_tb.sv
